FILE: hdl/elts_pkg.sv
// Package for the energy-loss table sampler: table sizes, field widths,
// beat structs and item kind codes. No dependencies.
package elts_pkg;

    localparam int MAX_ENERGIES = 64;
    localparam int MAX_POINTS   = 64;
    localparam int ROW_W        = $clog2(MAX_ENERGIES);
    localparam int PT_W         = $clog2(MAX_POINTS);
    localparam int CELL_W       = ROW_W + PT_W;
    localparam int CELLS        = MAX_ENERGIES * MAX_POINTS;

    localparam logic [1:0] KIND_AXIS   = 2'd0;
    localparam logic [1:0] KIND_CELL   = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    localparam logic REG_ENERGIES = 1'b0;
    localparam logic REG_POINTS   = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  row_index;
        logic [5:0]  point_index;
        logic [23:0] energy;
        logic [15:0] cum_probability;
        logic [23:0] loss_value;
        logic [15:0] random_fraction;
    } t_in_beat;

    typedef struct packed {
        logic [23:0] sampled_loss;
        logic        hit;
    } t_out_beat;

endpackage

FILE: hdl/elts_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module elts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/energy_loss_table_sampler_core.sv
// Top level of the energy-loss table sampler: sequencer, axis and table RAMs,
// shared divider and multiply-accumulate. Depends on elts_pkg and elts_ram.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------
//  in      | in        | i_valid / o_stall   | elts_pkg::t_in_beat
//  out     | out       | o_valid / i_stall   | elts_pkg::t_out_beat
//  cfg     | in        | i_cfg_valid/o_cfg_ready | index, 7-bit data
//
// A load beat is accepted, then written to its RAM. A sample beat is accepted,
// then runs two binary searches with edge and bracket reads (each probe is one
// RAM read with registered data), two 16-step restoring divisions of one
// quotient bit a cycle (cut short when the fraction is 0 or saturated), and a
// multiply-accumulate over the four corners. An energy below axis[0] or a
// fraction below the row's first CDF entry ends the beat early with a miss.
// Most of a sample's time goes to the searches and the bit-serial divider.
// Reset clears the sequencer, the output valid and the two count registers
// (both to 64); the RAMs hold undefined data until written.
// A result waits in the output register while i_stall is high; the block
// accepts no new beat until that result is taken.
module energy_loss_table_sampler_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  elts_pkg::t_in_beat   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output elts_pkg::t_out_beat  o_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [6:0]           i_cfg_data
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WRITE = 4'd1;
    localparam logic [3:0] S_E0    = 4'd2;  // read axis[0]
    localparam logic [3:0] S_ESRCH = 4'd3;  // probe axis
    localparam logic [3:0] S_ELO   = 4'd4;  // read axis[e]
    localparam logic [3:0] S_EHI   = 4'd5;  // read axis[e+1]
    localparam logic [3:0] S_P0    = 4'd6;
    localparam logic [3:0] S_PSRCH = 4'd7;
    localparam logic [3:0] S_PLO   = 4'd8;
    localparam logic [3:0] S_PHI   = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_MAC   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    localparam int RW = elts_pkg::ROW_W;
    localparam int PW = elts_pkg::PT_W;
    localparam int CW = elts_pkg::CELL_W;

    logic [3:0]  r_state;
    logic        r_rd;              // 0: address issued, 1: data present
    elts_pkg::t_in_beat r_in;
    logic [6:0]  r_ne, r_np;
    logic [RW:0] r_ea, r_eb;
    logic [PW:0] r_pa, r_pb;
    logic [23:0] r_lo, r_hi;
    logic [23:0] r_plo, r_phi;
    logic        r_divsel;          // 0: fx, 1: fy
    logic [4:0]  r_cnt;
    logic [40:0] r_rem;
    logic [16:0] r_quo;
    logic [24:0] r_den;
    logic [16:0] r_fx, r_fy;
    logic [1:0]  r_mac;
    logic [33:0] r_prod;
    logic [65:0] r_acc;
    logic        r_hit;
    logic        r_ovalid;
    logic [23:0] r_oloss;

    // Clamped counts as last index.
    logic [RW:0] w_ne_last;
    logic [PW:0] w_np_last;
    always_comb begin
        if (r_ne < 7'd2) w_ne_last = (RW+1)'(1);
        else if (r_ne > 7'(elts_pkg::MAX_ENERGIES)) w_ne_last = (RW+1)'(elts_pkg::MAX_ENERGIES-1);
        else w_ne_last = (RW+1)'(r_ne - 7'd1);
        if (r_np < 7'd2) w_np_last = (PW+1)'(1);
        else if (r_np > 7'(elts_pkg::MAX_POINTS)) w_np_last = (PW+1)'(elts_pkg::MAX_POINTS-1);
        else w_np_last = (PW+1)'(r_np - 7'd1);
    end

    logic [RW:0] w_em;
    logic [PW:0] w_pm;
    assign w_em = (r_ea + r_eb) >> 1;
    assign w_pm = (r_pa + r_pb) >> 1;

    // RAMs
    logic            w_ax_we, w_cl_we;
    logic [RW-1:0]   w_ax_raddr;
    logic [CW-1:0]   w_cl_raddr;
    logic [23:0]     w_ax_rdata, w_loss_rdata;
    logic [15:0]     w_cdf_rdata;
    logic [RW-1:0]   w_mrow;
    logic [PW-1:0]   w_mpt;

    assign w_ax_we = (r_state == S_WRITE) && (r_in.kind == elts_pkg::KIND_AXIS)
                     && ({2'b0, r_in.row_index} < 8'(elts_pkg::MAX_ENERGIES));
    assign w_cl_we = (r_state == S_WRITE) && (r_in.kind == elts_pkg::KIND_CELL)
                     && ({2'b0, r_in.row_index} < 8'(elts_pkg::MAX_ENERGIES))
                     && ({2'b0, r_in.point_index} < 8'(elts_pkg::MAX_POINTS));

    always_comb begin
        unique case (r_state)
            S_E0:    w_ax_raddr = '0;
            S_ESRCH: w_ax_raddr = w_em[RW-1:0];
            S_ELO:   w_ax_raddr = r_ea[RW-1:0];
            default: w_ax_raddr = RW'(r_ea + 1'b1);
        endcase
    end

    always_comb begin
        // MAC order: (e,o),(e,o+1),(e+1,o),(e+1,o+1)
        w_mrow = r_ea[RW-1:0] + RW'(r_mac[1]);
        w_mpt  = r_pa[PW-1:0] + PW'(r_mac[0]);
        unique case (r_state)
            S_P0:    w_cl_raddr = {r_ea[RW-1:0], PW'(0)};
            S_PSRCH: w_cl_raddr = {r_ea[RW-1:0], w_pm[PW-1:0]};
            S_PLO:   w_cl_raddr = {r_ea[RW-1:0], r_pa[PW-1:0]};
            S_PHI:   w_cl_raddr = {r_ea[RW-1:0], PW'(r_pa + 1'b1)};
            default: w_cl_raddr = {w_mrow, w_mpt};
        endcase
    end

    elts_ram #(.WIDTH(24), .DEPTH(elts_pkg::MAX_ENERGIES)) u_axis (
        .i_clk(i_clk), .i_we(w_ax_we), .i_waddr(r_in.row_index[RW-1:0]),
        .i_wdata(r_in.energy), .i_raddr(w_ax_raddr), .o_rdata(w_ax_rdata));
    elts_ram #(.WIDTH(16), .DEPTH(elts_pkg::CELLS)) u_cdf (
        .i_clk(i_clk), .i_we(w_cl_we),
        .i_waddr({r_in.row_index[RW-1:0], r_in.point_index[PW-1:0]}),
        .i_wdata(r_in.cum_probability), .i_raddr(w_cl_raddr), .o_rdata(w_cdf_rdata));
    elts_ram #(.WIDTH(24), .DEPTH(elts_pkg::CELLS)) u_loss (
        .i_clk(i_clk), .i_we(w_cl_we),
        .i_waddr({r_in.row_index[RW-1:0], r_in.point_index[PW-1:0]}),
        .i_wdata(r_in.loss_value), .i_raddr(w_cl_raddr), .o_rdata(w_loss_rdata));

    // Division operands, chosen by r_divsel.
    logic [23:0] w_v, w_dlo, w_dhi;
    assign w_v   = r_divsel ? {8'd0, r_in.random_fraction} : r_in.energy;
    assign w_dlo = r_divsel ? r_plo : r_lo;
    assign w_dhi = r_divsel ? r_phi : r_hi;

    logic [41:0] w_trial;
    assign w_trial = {r_rem, 1'b0} - {17'd0, r_den};

    // Weights for the current MAC term.
    logic [16:0] w_wx, w_wy;
    assign w_wx = r_mac[1] ? r_fx : (17'h10000 - r_fx);
    assign w_wy = r_mac[0] ? r_fy : (17'h10000 - r_fy);

    logic [33:0] w_wxy;
    assign w_wxy = w_wx * w_wy;

    logic [57:0] w_term;
    assign w_term = r_prod * w_loss_rdata;

    assign o_stall     = (r_state != S_IDLE) || r_ovalid;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid     = r_ovalid;
    assign o_data.sampled_loss = r_oloss;
    assign o_data.hit          = r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ne     <= 7'd64;
            r_np     <= 7'd64;
            r_rd     <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == elts_pkg::REG_ENERGIES) r_ne <= i_cfg_data;
                else r_np <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_in <= i_data;
                        r_rd <= 1'b0;
                        if (i_data.kind == elts_pkg::KIND_SAMPLE) begin
                            r_ea    <= '0;
                            r_eb    <= w_ne_last;
                            r_state <= S_E0;
                        end else if (i_data.kind == elts_pkg::KIND_AXIS
                                     || i_data.kind == elts_pkg::KIND_CELL) begin
                            r_state <= S_WRITE;
                        end
                        // drop unused kind: stay idle
                    end
                end
                S_WRITE: r_state <= S_IDLE;
                S_E0: begin
                    r_rd <= !r_rd;
                    if (r_rd) begin
                        if (r_in.energy < w_ax_rdata) begin
                            r_hit <= 1'b0; r_oloss <= '0; r_state <= S_OUT;
                        end else r_state <= S_ESRCH;
                    end
                end
                S_ESRCH: begin
                    if (r_eb - r_ea <= 1) begin
                        r_state <= S_ELO; r_rd <= 1'b0;
                    end else begin
                        r_rd <= !r_rd;
                        if (r_rd) begin
                            if (w_ax_rdata > r_in.energy) r_eb <= w_em;
                            else r_ea <= w_em;
                        end
                    end
                end
                S_ELO: begin
                    r_rd <= !r_rd;
                    if (r_rd) begin r_lo <= w_ax_rdata; r_state <= S_EHI; end
                end
                S_EHI: begin
                    r_rd <= !r_rd;
                    if (r_rd) begin
                        r_hi <= w_ax_rdata; r_state <= S_P0;
                        r_pa <= '0; r_pb <= w_np_last;
                    end
                end
                S_P0: begin
                    r_rd <= !r_rd;
                    if (r_rd) begin
                        if (r_in.random_fraction < w_cdf_rdata) begin
                            r_hit <= 1'b0; r_oloss <= '0; r_state <= S_OUT;
                        end else r_state <= S_PSRCH;
                    end
                end
                S_PSRCH: begin
                    if (r_pb - r_pa <= 1) begin
                        r_state <= S_PLO; r_rd <= 1'b0;
                    end else begin
                        r_rd <= !r_rd;
                        if (r_rd) begin
                            if (w_cdf_rdata > r_in.random_fraction) r_pb <= w_pm;
                            else r_pa <= w_pm;
                        end
                    end
                end
                S_PLO: begin
                    r_rd <= !r_rd;
                    if (r_rd) begin r_plo <= {8'd0, w_cdf_rdata}; r_state <= S_PHI; end
                end
                S_PHI: begin
                    r_rd <= !r_rd;
                    if (r_rd) begin
                        r_phi <= {8'd0, w_cdf_rdata}; r_state <= S_DIV;
                        r_divsel <= 1'b0; r_cnt <= '0;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 5'd0) begin
                        // Set up: settle flat, below and saturated brackets.
                        r_rem <= {17'd0, w_v - w_dlo};
                        r_den <= {1'b0, w_dhi - w_dlo};
                        if (w_v <= w_dlo) begin
                            r_quo <= '0; r_cnt <= 5'd31;
                        end else if (w_dhi <= w_dlo || (w_dhi - w_dlo) <= (w_v - w_dlo)) begin
                            r_quo <= 17'h10000; r_cnt <= 5'd31;
                        end else begin
                            r_quo <= '0; r_cnt <= 5'd1;
                        end
                    end else if (r_cnt != 5'd31) begin
                        // One quotient bit a cycle; num < den so 16 bits.
                        if (!w_trial[41]) begin
                            r_rem <= w_trial[40:0]; r_quo <= {r_quo[15:0], 1'b1};
                        end else begin
                            r_rem <= r_rem << 1;    r_quo <= {r_quo[15:0], 1'b0};
                        end
                        r_cnt <= (r_cnt == 5'd16) ? 5'd31 : r_cnt + 5'd1;
                    end else begin
                        if (!r_divsel) begin
                            r_fx <= r_quo; r_divsel <= 1'b1; r_cnt <= '0;
                        end else begin
                            r_fy <= r_quo; r_state <= S_MAC;
                            r_mac <= '0; r_acc <= '0; r_rd <= 1'b0;
                        end
                    end
                end
                S_MAC: begin
                    // Each term: issue the read and register the weight product, then multiply-add.
                    r_rd <= !r_rd;
                    if (!r_rd) r_prod <= w_wxy;
                    else begin
                        r_acc <= r_acc + 66'(w_term);
                        if (r_mac == 2'd3) begin
                            r_state <= S_OUT; r_hit <= 1'b1;
                        end
                        r_mac <= r_mac + 2'd1;
                    end
                end
                S_OUT: begin
                    if (r_hit) r_oloss <= 24'((r_acc + 66'h80000000) >> 32);
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: ;
            endcase
        end
    end
endmodule
